// File: rtl/amx_pkg.sv
// ----------------------------------------------------------------------------
// Accumulator machine executor package
// Shared types and constants: field widths, decode constants, opcodes and
// the sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package amx_pkg;

   // Instruction word and decode widths
   localparam int INSTR_BITS = 18;
   localparam int MAG_BITS   = 17;   // magnitude of a non-negative word
   localparam int OPC_BITS   = 11;   // largest opcode is 131071 / 100 = 1310
   localparam int ADDR_BITS  = 7;
   localparam int MEM_WORDS  = 100;
   localparam int VALUE_BITS = 32;

   // Divide by 100 as multiply by a rounded-up reciprocal, exact below 2^17
   localparam int RECIP_BITS  = 18;
   localparam int RECIP_SHIFT = 24;
   localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_100 = 18'd167773;
   localparam logic [MAG_BITS-1:0]   RADIX     = 17'd100;

   // Opcodes
   localparam logic [OPC_BITS-1:0] OP_READ  = 11'd10;
   localparam logic [OPC_BITS-1:0] OP_WRITE = 11'd11;
   localparam logic [OPC_BITS-1:0] OP_LOAD  = 11'd20;
   localparam logic [OPC_BITS-1:0] OP_STORE = 11'd21;
   localparam logic [OPC_BITS-1:0] OP_ADD   = 11'd30;
   localparam logic [OPC_BITS-1:0] OP_SUB   = 11'd31;
   localparam logic [OPC_BITS-1:0] OP_DIV   = 11'd32;
   localparam logic [OPC_BITS-1:0] OP_MUL   = 11'd33;

   // Sequencer states
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_QUOT  = 7'b0000010,
      ST_ADDR  = 7'b0000100,
      ST_FETCH = 7'b0001000,
      ST_EXEC  = 7'b0010000,
      ST_ITER  = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

// File: rtl/accumulator_machine_executor_core.sv
// ----------------------------------------------------------------------------
// Accumulator machine executor
// Runs one accumulator-machine instruction per input item against a
// 100-word data memory and an accumulator, using one shared adder for
// add, subtract and the bit-serial multiply and divide.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one instruction per item: the instruction word, the value
//   a read instruction stores, and tlast marking the last instruction of a
//   program. rsp_* returns exactly one item per instruction: the printed
//   word of a write instruction, a write-valid flag, a divide-by-zero flag
//   and tlast echoing the program end mark.
//   req_tready is high only while the sequencer is idle, so a new item is
//   taken only once the last is through. An item steps through the opcode,
//   address, fetch, execute and final states; multiply and divide insert
//   an iterate state between execute and final that steps the shared adder
//   once per bit (not for a divide by zero). The result is loaded into the
//   output register as the sequencer leaves the final state.
//   The result sits in an output register: when the receiver stalls the
//   next item is still accepted and worked on, and the sequencer holds in
//   its final state only until the earlier result has been taken.
//   Reset clears the accumulator and marks every memory word as zero
//   through per-word valid bits, so the block is ready in the first cycle
//   after reset with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module accumulator_machine_executor_core #(
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // instruction in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // [17:0] instr_word, [49:18] read_value, rest zero
   input  logic        req_tlast,   // program_end
   // result out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] write_value
   output logic [1:0]  rsp_tuser,   // [0] write_valid, [1] divide_by_zero
   output logic        rsp_tlast    // program_done
);

   localparam int CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   // Sequencer
   amx_pkg::state_type state_ff, state_in;

   // Captured item
   logic [amx_pkg::INSTR_BITS-1:0] word_ff, word_in;
   logic [amx_pkg::VALUE_BITS-1:0] rv_ff, rv_in;
   logic                           last_ff, last_in;

   // Decode
   logic [amx_pkg::OPC_BITS-1:0]   opc_ff, opc_in;
   logic [amx_pkg::ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [amx_pkg::PROD_BITS-1:0]  recip_prod;
   logic [amx_pkg::MAG_BITS-1:0]   addr_full;

   // Data memory with per-word valid bits
   logic [WORD_BITS-1:0]           mem [amx_pkg::MEM_WORDS];
   logic [amx_pkg::MEM_WORDS-1:0]  valid_ff;
   logic [WORD_BITS-1:0]           rdata_ff;
   logic                           rvalid_ff;
   logic                           mem_we;
   logic [WORD_BITS-1:0]           mem_wdata;
   logic [WORD_BITS-1:0]           operand;

   // Accumulator and iteration registers
   logic [WORD_BITS-1:0]           acc_ff, acc_in;
   logic [WORD_BITS-1:0]           rem_ff, rem_in;   // remainder / product
   logic [WORD_BITS-1:0]           quo_ff, quo_in;   // dividend-quotient / multiplier
   logic [WORD_BITS-1:0]           dvs_ff, dvs_in;   // divisor / multiplicand
   logic [CNT_BITS-1:0]            cnt_ff, cnt_in;
   logic                           negq_ff, negq_in;

   // Shared adder
   logic [WORD_BITS-1:0]           alu_a, alu_b;
   logic                           alu_sub;
   logic [WORD_BITS:0]             alu_sum;

   // Result fields and output register
   logic                           wvalid_ff, wvalid_in;
   logic [amx_pkg::VALUE_BITS-1:0] wvalue_ff, wvalue_in;
   logic                           dz_ff, dz_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]                    rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]                     rsp_tuser_ff, rsp_tuser_in;
   logic                           rsp_tlast_ff, rsp_tlast_in;
   logic                           out_free;

   assign req_tready = (state_ff == amx_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // Opcode: magnitude times the reciprocal of 100, keep the top bits
   assign recip_prod = amx_pkg::PROD_BITS'(word_ff[amx_pkg::MAG_BITS-1:0])
                     * amx_pkg::PROD_BITS'(amx_pkg::RECIP_100);
   // Address: magnitude less opcode times 100, always below 100
   assign addr_full  = word_ff[amx_pkg::MAG_BITS-1:0]
                     - amx_pkg::MAG_BITS'(amx_pkg::MAG_BITS'(opc_ff) * amx_pkg::RADIX);

   // Never-written words read as zero
   assign operand = rvalid_ff ? rdata_ff : '0;

   // One adder serves add, subtract, divide steps and multiply steps
   assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {WORD_BITS{alu_sub}}}
                  + (WORD_BITS + 1)'(alu_sub);

   always_comb begin
      state_in  = state_ff;
      word_in   = word_ff;
      rv_in     = rv_ff;
      last_in   = last_ff;
      opc_in    = opc_ff;
      addr_in   = addr_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      negq_in   = negq_ff;
      wvalid_in = wvalid_ff;
      wvalue_in = wvalue_ff;
      dz_in     = dz_ff;
      mem_we    = 1'b0;
      mem_wdata = acc_ff;
      alu_a     = acc_ff;
      alu_b     = operand;
      alu_sub   = 1'b0;

      unique case (state_ff)
         amx_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               word_in   = req_tdata[amx_pkg::INSTR_BITS-1:0];
               rv_in     = req_tdata[amx_pkg::INSTR_BITS +: amx_pkg::VALUE_BITS];
               last_in   = req_tlast;
               wvalid_in = 1'b0;
               wvalue_in = '0;
               dz_in     = 1'b0;
               state_in  = amx_pkg::ST_QUOT;
            end
         end
         amx_pkg::ST_QUOT: begin
            opc_in   = recip_prod[amx_pkg::RECIP_SHIFT +: amx_pkg::OPC_BITS];
            state_in = amx_pkg::ST_ADDR;
         end
         amx_pkg::ST_ADDR: begin
            addr_in  = addr_full[amx_pkg::ADDR_BITS-1:0];
            state_in = amx_pkg::ST_FETCH;
         end
         amx_pkg::ST_FETCH: begin
            state_in = amx_pkg::ST_EXEC;
         end
         amx_pkg::ST_EXEC: begin
            state_in = amx_pkg::ST_FIN;
            // negative words decode to no operation
            if (!word_ff[amx_pkg::INSTR_BITS-1]) begin
               unique case (opc_ff)
                  amx_pkg::OP_READ: begin
                     mem_we    = 1'b1;
                     mem_wdata = WORD_BITS'($signed(rv_ff));
                  end
                  amx_pkg::OP_WRITE: begin
                     wvalid_in = 1'b1;
                     wvalue_in = amx_pkg::VALUE_BITS'(operand);
                  end
                  amx_pkg::OP_LOAD: begin
                     acc_in = operand;
                  end
                  amx_pkg::OP_STORE: begin
                     mem_we    = 1'b1;
                     mem_wdata = acc_ff;
                  end
                  amx_pkg::OP_ADD: begin
                     acc_in = alu_sum[WORD_BITS-1:0];
                  end
                  amx_pkg::OP_SUB: begin
                     alu_sub = 1'b1;
                     acc_in  = alu_sum[WORD_BITS-1:0];
                  end
                  amx_pkg::OP_DIV: begin
                     if (operand == '0) begin
                        dz_in = 1'b1;
                     end else begin
                        // divide magnitudes, fix the sign at the end
                        negq_in  = acc_ff[WORD_BITS-1] ^ operand[WORD_BITS-1];
                        quo_in   = acc_ff[WORD_BITS-1] ? -acc_ff : acc_ff;
                        dvs_in   = operand[WORD_BITS-1] ? -operand : operand;
                        rem_in   = '0;
                        cnt_in   = CNT_LAST;
                        state_in = amx_pkg::ST_ITER;
                     end
                  end
                  amx_pkg::OP_MUL: begin
                     rem_in   = '0;
                     quo_in   = operand;
                     dvs_in   = acc_ff;
                     cnt_in   = CNT_LAST;
                     state_in = amx_pkg::ST_ITER;
                  end
                  default: begin
                  end
               endcase
            end
         end
         amx_pkg::ST_ITER: begin
            if (opc_ff == amx_pkg::OP_DIV) begin
               // restoring step: shift in the next dividend bit, trial subtract
               alu_a   = {rem_ff[WORD_BITS-2:0], quo_ff[WORD_BITS-1]};
               alu_b   = dvs_ff;
               alu_sub = 1'b1;
               rem_in  = alu_sum[WORD_BITS] ? alu_sum[WORD_BITS-1:0] : alu_a;
               quo_in  = {quo_ff[WORD_BITS-2:0], alu_sum[WORD_BITS]};
               if (cnt_ff == '0) begin
                  acc_in = negq_ff ? -{quo_ff[WORD_BITS-2:0], alu_sum[WORD_BITS]}
                                   :  {quo_ff[WORD_BITS-2:0], alu_sum[WORD_BITS]};
               end
            end else begin
               // shift-add step, low bits only
               alu_a  = rem_ff;
               alu_b  = dvs_ff;
               rem_in = quo_ff[0] ? alu_sum[WORD_BITS-1:0] : rem_ff;
               quo_in = quo_ff >> 1;
               dvs_in = dvs_ff << 1;
               if (cnt_ff == '0) begin
                  acc_in = quo_ff[0] ? alu_sum[WORD_BITS-1:0] : rem_ff;
               end
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = amx_pkg::ST_FIN;
            end
         end
         amx_pkg::ST_FIN: begin
            // hold until the output register is free
            if (out_free) begin
               state_in = amx_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = amx_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      priority if (state_ff == amx_pkg::ST_FIN && out_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = wvalue_ff;
         rsp_tuser_in  = {dz_ff, wvalid_ff};
         rsp_tlast_in  = last_ff;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= amx_pkg::ST_IDLE;
         acc_ff        <= '0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (mem_we) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // Payload and datapath registers
   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      rv_ff        <= rv_in;
      last_ff      <= last_in;
      opc_ff       <= opc_in;
      addr_ff      <= addr_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvs_ff       <= dvs_in;
      cnt_ff       <= cnt_in;
      negq_ff      <= negq_in;
      wvalid_ff    <= wvalid_in;
      wvalue_ff    <= wvalue_in;
      dz_ff        <= dz_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   // Data memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      if (state_ff == amx_pkg::ST_FETCH) begin
         rdata_ff  <= mem[addr_ff];
         rvalid_ff <= valid_ff[addr_ff];
      end
   end

endmodule

`default_nettype wire

// File: rtl/amx_checker.sv
// ----------------------------------------------------------------------------
// Accumulator machine executor checker
// Port-level assertions on the executor, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module amx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The sequencer is busy right after it takes an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after accepting an item");

   // A write and a divide-by-zero never come from one instruction
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("write and divide-by-zero flags both set");

   // Only a write instruction carries a data word
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("data word present without a write");

   // Reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind accumulator_machine_executor_core amx_checker u_amx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
